// ===== design/rbo_pkg.sv =====
// Shared constants, request and status codes for the ray/box occlusion core.
`default_nettype none
package rbo_pkg;

    // Box table geometry
    localparam int MAX_BOXES = 2048;
    localparam int BOX_IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int ROT_DEPTH = 3 * MAX_BOXES;
    localparam int ROT_AW    = $clog2(ROT_DEPTH);

    // Word layout
    localparam int COORD_W = 32;
    localparam int VEC_W   = 3 * COORD_W;

    // Request kinds
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_ROT    = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_BOX = 2'd2;

    // Rotation row select that writes nothing
    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef logic signed [COORD_W-1:0] q14_t;
    typedef logic [VEC_W-1:0]          vec3_t;

endpackage
`default_nettype wire

// ===== design/ray_box_occlusion_test_core.sv =====
// Ray occlusion test core: oriented box table plus an iterative slab-test query engine.
//
// Table loads (clear, append, rotation row) are taken in the idle state and their result
// word is registered and appears in the cycle after the load is accepted. A query first works
// on the segment (three squares, a 32-step square root and three 68-step divisions), then
// walks the stored boxes in order; a box skipped by the distance tests is left early, and
// for a box that reaches the slab test the six 68-step divisions on the one shared
// restoring divider dominate. A query that hits stops at the first blocking box.
// All multiplications run through one 34x34 multiplier and all divisions through one divider
// under the sequencer; the input side is not ready while a query is in flight. After reset
// the box table holds no boxes and needs no clearing pass.
`default_nettype none
module ray_box_occlusion_test_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] x_a, [63:32] y_a, [95:64] z_a, [127:96] x_b, [159:128] y_b, [191:160] z_b
    input  wire logic [191:0] s_axis_tdata,
    // [1:0] req_type, [3:2] row_select
    input  wire logic [3:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] visible, [7:1] zero
    output logic [7:0]        m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser
);
    import rbo_pkg::*;

    localparam int DIV_STEPS = 68;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DSQ   = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_UDIV  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_UQ    = 4'd5;
    localparam logic [3:0] S_BOX   = 4'd6;
    localparam logic [3:0] S_PDIST = 4'd7;
    localparam logic [3:0] S_FAR   = 4'd8;
    localparam logic [3:0] S_EF    = 4'd9;
    localparam logic [3:0] S_SLAB  = 4'd10;
    localparam logic [3:0] S_SLABQ = 4'd11;
    localparam logic [3:0] S_HIT   = 4'd12;
    localparam logic [3:0] S_NEXT  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [67:0] dvd_of(input logic signed [55:0] num);
        logic signed [55:0] mag;
        mag = num[55] ? -num : num;
        return {mag[53:0], 14'b0};
    endfunction

    // Control and datapath registers
    logic [3:0]               state_reg, state_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [1:0]               ax_reg, ax_next;
    logic                     half_reg, half_next;
    logic                     ret_reg, ret_next;
    logic [CNT_W-1:0]         box_count_reg, box_count_next;
    logic [CNT_W-1:0]         b_reg, b_next;
    q14_t                     cam_reg [3], cam_next [3];
    logic signed [32:0]       d_reg [3], d_next [3];
    logic [63:0]              acc_reg, acc_next;
    logic [63:0]              sq_n_reg, sq_n_next;
    logic [63:0]              sq_res_reg, sq_res_next;
    logic [63:0]              sq_bit_reg, sq_bit_next;
    logic [31:0]              len_reg, len_next;
    logic signed [15:0]       u_reg [3], u_next [3];
    logic signed [32:0]       p_reg [3], p_next [3];
    q14_t                     sz_reg [3], sz_next [3];
    q14_t                     m_reg, m_next;
    logic [34:0]              lim_abs_reg, lim_abs_next;
    logic signed [52:0]       e_reg [3], e_next [3];
    logic signed [34:0]       f_reg [3], f_next [3];
    logic [67:0]              div_dvd_reg, div_dvd_next;
    logic [35:0]              div_rem_reg, div_rem_next;
    logic [35:0]              div_den_reg, div_den_next;
    logic                     div_neg_reg, div_neg_next;
    logic [6:0]               div_cnt_reg, div_cnt_next;
    logic signed [41:0]       tq_reg, tq_next;
    logic signed [41:0]       t1_reg, t1_next;
    logic signed [41:0]       tmin_reg, tmin_next;
    logic signed [41:0]       tmax_reg, tmax_next;
    logic signed [67:0]       mul_p_reg, mul_p_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_vis_reg, m_vis_next;
    logic [1:0]               m_status_reg, m_status_next;

    // Box table storage and its registered read words
    vec3_t                    ctr_mem [MAX_BOXES];
    vec3_t                    siz_mem [MAX_BOXES];
    vec3_t                    rot_mem [ROT_DEPTH];
    vec3_t                    ctr_q, siz_q, rot_q;
    logic                     box_we, rot_we;
    logic [ROT_AW-1:0]        rot_waddr, rot_raddr;

    logic                     s_fire;
    logic [1:0]               req_type, row_select;
    logic signed [33:0]       mul_a, mul_b;
    logic signed [33:0]       abs_d [3];
    logic signed [53:0]       e2_cur;
    logic signed [55:0]       num_lo, num_hi;
    logic signed [35:0]       den2;
    logic [35:0]              den_mag;
    logic [CNT_W-1:0]         last_b;

    assign req_type   = s_axis_tuser[1:0];
    assign row_select = s_axis_tuser[3:2];
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_fire = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_vis_reg};
    assign m_axis_tuser  = m_status_reg;

    // Table addresses
    assign last_b    = box_count_reg - CNT_W'(1);
    assign rot_waddr = ROT_AW'({last_b[BOX_IDX_W-1:0], 1'b0}) + ROT_AW'(last_b[BOX_IDX_W-1:0])
                     + ROT_AW'(row_select);
    assign rot_raddr = ROT_AW'({b_reg[BOX_IDX_W-1:0], 1'b0}) + ROT_AW'(b_reg[BOX_IDX_W-1:0])
                     + ROT_AW'(ax_reg);

    // Slab operands for the current axis
    assign e2_cur  = {e_reg[ax_reg], 1'b0};
    assign num_lo  = 56'(e2_cur) - 56'(sz_reg[ax_reg]);
    assign num_hi  = 56'(e2_cur) + 56'(sz_reg[ax_reg]);
    assign den2    = {f_reg[ax_reg], 1'b0};
    assign den_mag = den2[35] ? 36'(-den2) : 36'(den2);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_d[i] = d_reg[i][32] ? -34'(d_reg[i]) : 34'(d_reg[i]);
        end
    end

    // Table write and read ports
    always_ff @(posedge aclk) begin
        if (box_we) begin
            ctr_mem[box_count_reg[BOX_IDX_W-1:0]] <= s_axis_tdata[95:0];
            siz_mem[box_count_reg[BOX_IDX_W-1:0]] <= s_axis_tdata[191:96];
        end
        if (rot_we) begin
            rot_mem[rot_waddr] <= s_axis_tdata[95:0];
        end
        ctr_q <= ctr_mem[b_reg[BOX_IDX_W-1:0]];
        siz_q <= siz_mem[b_reg[BOX_IDX_W-1:0]];
        rot_q <= rot_mem[rot_raddr];
    end

    // Sequencer and shared datapath
    always_comb begin
        logic [2:0]         j;
        logic [1:0]         jf;
        logic [36:0]        rem_sh;
        logic [36:0]        rem_sub;
        logic               qb;
        logic [41:0]        qmag;
        logic [63:0]        rb;
        logic [63:0]        res_new;
        logic signed [32:0] m33;
        logic signed [32:0] neg_m33;
        logic signed [32:0] half_m;
        logic signed [34:0] lim_s;
        logic signed [67:0] prod_f14;
        logic               far_skip;
        logic               near_skip;
        logic signed [41:0] lo, hi, nmin, nmax;
        q14_t               mx;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ax_next        = ax_reg;
        half_next      = half_reg;
        ret_next       = ret_reg;
        box_count_next = box_count_reg;
        b_next         = b_reg;
        cam_next       = cam_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        sq_n_next      = sq_n_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        len_next       = len_reg;
        u_next         = u_reg;
        p_next         = p_reg;
        sz_next        = sz_reg;
        m_next         = m_reg;
        lim_abs_next   = lim_abs_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        div_dvd_next   = div_dvd_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_neg_next   = div_neg_reg;
        div_cnt_next   = div_cnt_reg;
        tq_next        = tq_reg;
        t1_next        = t1_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        m_valid_next   = m_valid_reg;
        m_vis_next     = m_vis_reg;
        m_status_next  = m_status_reg;
        box_we         = 1'b0;
        rot_we         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        j              = 3'(cnt_reg) - 3'd1;
        jf             = j[1:0] - 2'd3;
        rem_sh         = {div_rem_reg, div_dvd_reg[67]};
        rem_sub        = rem_sh - {1'b0, div_den_reg};
        qb             = (rem_sh >= {1'b0, div_den_reg});
        qmag           = '0;
        rb             = sq_res_reg + sq_bit_reg;
        res_new        = '0;
        m33            = 33'(m_reg);
        neg_m33        = -m33;
        half_m         = m33[32] ? -(neg_m33 >>> 1) : (m33 >>> 1);
        lim_s          = 35'($signed({1'b0, len_reg})) + 35'(m_reg) + 35'(half_m);
        prod_f14       = mul_p_reg >>> 14;
        far_skip       = (lim_abs_reg[34:32] == 3'b0) && (acc_reg > mul_p_reg[63:0]);
        near_skip      = (acc_reg < 64'h1000_0000);
        lo             = (t1_reg > tq_reg) ? tq_reg : t1_reg;
        hi             = (t1_reg > tq_reg) ? t1_reg : tq_reg;
        nmin           = (lo > tmin_reg) ? lo : tmin_reg;
        nmax           = (hi < tmax_reg) ? hi : tmax_reg;
        mx             = '0;

        // Drop the result word once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    m_vis_next    = 1'b0;
                    m_status_next = ST_DONE;
                    case (req_type)
                        REQ_CLEAR: begin
                            box_count_next = '0;
                            m_valid_next   = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (box_count_reg >= CNT_W'(MAX_BOXES)) begin
                                m_status_next = ST_FULL;
                            end else begin
                                box_we         = 1'b1;
                                box_count_next = box_count_reg + CNT_W'(1);
                            end
                            m_valid_next = 1'b1;
                        end
                        REQ_ROT: begin
                            if (box_count_reg == '0) begin
                                m_status_next = ST_NO_BOX;
                            end else if (row_select != ROW_NONE) begin
                                rot_we = 1'b1;
                            end
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            for (int i = 0; i < 3; i++) begin
                                cam_next[i] = s_axis_tdata[32*i +: 32];
                                d_next[i]   = 33'($signed(s_axis_tdata[96+32*i +: 32]))
                                            - 33'($signed(s_axis_tdata[32*i +: 32]));
                            end
                            acc_next   = '0;
                            cnt_next   = '0;
                            state_next = S_DSQ;
                        end
                    endcase
                end
            end

            // Squared segment length
            S_DSQ: begin
                if (cnt_reg < 5'd3) begin
                    mul_a = abs_d[cnt_reg[1:0]];
                    mul_b = abs_d[cnt_reg[1:0]];
                end
                if (cnt_reg != 5'd0) begin
                    acc_next = sat_add(acc_reg, mul_p_reg[63:0]);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3) begin
                    cnt_next = '0;
                    if (acc_next == '0) begin
                        m_vis_next = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        sq_n_next   = acc_next;
                        sq_res_next = '0;
                        sq_bit_next = 64'h4000_0000_0000_0000;
                        state_next  = S_SQRT;
                    end
                end
            end

            // One root digit per cycle
            S_SQRT: begin
                if (sq_n_reg >= rb) begin
                    sq_n_next = sq_n_reg - rb;
                    res_new   = (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    res_new   = sq_res_reg >> 1;
                end
                sq_res_next = res_new;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    len_next   = res_new[31:0];
                    ax_next    = '0;
                    state_next = S_UDIV;
                end
            end

            // Start a direction-component division
            S_UDIV: begin
                div_dvd_next = {20'b0, abs_d[ax_reg], 14'b0};
                div_den_next = {4'b0, len_reg};
                div_neg_next = d_reg[ax_reg][32];
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = 1'b0;
                state_next   = S_DIV;
            end

            // Restoring divider, one quotient bit per cycle
            S_DIV: begin
                div_rem_next = qb ? rem_sub[35:0] : rem_sh[35:0];
                div_dvd_next = {div_dvd_reg[66:0], qb};
                div_cnt_next = div_cnt_reg + 7'd1;
                if (div_cnt_reg == 7'(DIV_STEPS - 1)) begin
                    qmag = (div_dvd_next[67:40] != '0) ? 42'h100_0000_0000
                                                       : {2'b0, div_dvd_next[39:0]};
                    tq_next    = div_neg_reg ? -$signed(qmag) : $signed(qmag);
                    state_next = ret_reg ? S_SLABQ : S_UQ;
                end
            end

            S_UQ: begin
                u_next[ax_reg] = tq_reg[15:0];
                if (ax_reg == 2'd2) begin
                    b_next = '0;
                    if (box_count_reg == '0) begin
                        m_vis_next = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_BOX;
                    end
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_UDIV;
                end
            end

            // Wait for the table read of this box
            S_BOX: begin
                ax_next    = '0;
                cnt_next   = '0;
                state_next = S_PDIST;
            end

            // Offset to box center and its squared distance
            S_PDIST: begin
                if (cnt_reg == 5'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        p_next[i]  = 33'($signed(ctr_q[32*i +: 32])) - 33'(cam_reg[i]);
                        sz_next[i] = siz_q[32*i +: 32];
                    end
                    mx = sz_next[0];
                    if (sz_next[1] > mx) mx = sz_next[1];
                    if (sz_next[2] > mx) mx = sz_next[2];
                    m_next   = mx;
                    acc_next = '0;
                end else if (cnt_reg < 5'd4) begin
                    mul_a = p_reg[j[1:0]][32] ? -34'(p_reg[j[1:0]]) : 34'(p_reg[j[1:0]]);
                    mul_b = mul_a;
                end
                if (cnt_reg >= 5'd2) begin
                    acc_next = sat_add(acc_reg, mul_p_reg[63:0]);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    cnt_next   = '0;
                    state_next = S_FAR;
                end
            end

            // Far and near skip tests
            S_FAR: begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0: begin
                        lim_abs_next = lim_s[34] ? 35'(-lim_s) : 35'(lim_s);
                    end
                    5'd1: begin
                        mul_a = $signed({1'b0, lim_abs_reg[32:0]});
                        mul_b = mul_a;
                    end
                    default: begin
                        cnt_next = '0;
                        if (far_skip || near_skip) begin
                            state_next = S_NEXT;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                e_next[i] = '0;
                                f_next[i] = '0;
                            end
                            state_next = S_EF;
                        end
                    end
                endcase
            end

            // Box-frame offset and direction, one rotation row at a time
            S_EF: begin
                if (cnt_reg >= 5'd1 && cnt_reg <= 5'd3) begin
                    mul_a = 34'(p_reg[j[1:0]]);
                    mul_b = 34'($signed(rot_q[32*j[1:0] +: 32]));
                end else if (cnt_reg >= 5'd4 && cnt_reg <= 5'd6) begin
                    mul_a = 34'(u_reg[jf]);
                    mul_b = 34'($signed(rot_q[32*jf +: 32]));
                end
                if (cnt_reg >= 5'd2 && cnt_reg <= 5'd4) begin
                    e_next[ax_reg] = e_reg[ax_reg] + 53'(prod_f14);
                end else if (cnt_reg >= 5'd5) begin
                    f_next[ax_reg] = f_reg[ax_reg] + 35'(prod_f14);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7) begin
                    cnt_next = '0;
                    if (ax_reg == 2'd2) begin
                        ax_next    = '0;
                        tmin_next  = '0;
                        tmax_next  = 42'($signed({1'b0, len_reg})) - 42'sd8192;
                        state_next = S_SLAB;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end
            end

            // Parallel check or start the near-bound division
            S_SLAB: begin
                if (f_reg[ax_reg] == '0) begin
                    if (e2_cur < -54'(sz_reg[ax_reg]) || e2_cur > 54'(sz_reg[ax_reg])) begin
                        state_next = S_NEXT;
                    end else if (ax_reg == 2'd2) begin
                        state_next = S_HIT;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else begin
                    div_dvd_next = dvd_of(num_lo);
                    div_den_next = den_mag;
                    div_neg_next = num_lo[55] ^ den2[35];
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    half_next    = 1'b0;
                    ret_next     = 1'b1;
                    state_next   = S_DIV;
                end
            end

            // Hold first bound, or narrow the interval
            S_SLABQ: begin
                if (!half_reg) begin
                    t1_next      = tq_reg;
                    div_dvd_next = dvd_of(num_hi);
                    div_den_next = den_mag;
                    div_neg_next = num_hi[55] ^ den2[35];
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    half_next    = 1'b1;
                    state_next   = S_DIV;
                end else if (nmin > nmax) begin
                    state_next = S_NEXT;
                end else begin
                    tmin_next = nmin;
                    tmax_next = nmax;
                    if (ax_reg == 2'd2) begin
                        state_next = S_HIT;
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_SLAB;
                    end
                end
            end

            S_HIT: begin
                if (!tmax_reg[41]) begin
                    m_vis_next = 1'b0;
                    state_next = S_DONE;
                end else begin
                    state_next = S_NEXT;
                end
            end

            // Advance to the next box or finish unobstructed
            S_NEXT: begin
                if ((b_reg + CNT_W'(1)) >= box_count_reg) begin
                    m_vis_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    b_next     = b_reg + CNT_W'(1);
                    state_next = S_BOX;
                end
            end

            // Post the query word once the output register is free
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_DONE;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        mul_p_next = mul_a * mul_b;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        ax_reg       <= ax_next;
        half_reg     <= half_next;
        ret_reg      <= ret_next;
        b_reg        <= b_next;
        cam_reg      <= cam_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        sq_n_reg     <= sq_n_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        len_reg      <= len_next;
        u_reg        <= u_next;
        p_reg        <= p_next;
        sz_reg       <= sz_next;
        m_reg        <= m_next;
        lim_abs_reg  <= lim_abs_next;
        e_reg        <= e_next;
        f_reg        <= f_next;
        div_dvd_reg  <= div_dvd_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        div_neg_reg  <= div_neg_next;
        div_cnt_reg  <= div_cnt_next;
        tq_reg       <= tq_next;
        t1_reg       <= t1_next;
        tmin_reg     <= tmin_next;
        tmax_reg     <= tmax_next;
        mul_p_reg    <= mul_p_next;
        m_vis_reg    <= m_vis_next;
        m_status_reg <= m_status_next;
    end

    // Checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        box_count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table size");

    a_load_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && req_type != REQ_QUERY) |=> m_axis_tvalid)
        else $error("table load gave no result word");

    a_status_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> !m_axis_tdata[0])
        else $error("error status with visible set");

    a_box_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BOX || state_reg == S_EF || state_reg == S_SLAB)
        |-> b_reg < box_count_reg)
        else $error("box walk past table end");

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> div_cnt_reg < 7'(DIV_STEPS))
        else $error("divider ran past its step count");

endmodule
`default_nettype wire

// ===== verif/ray_box_occlusion_test_core_tb.sv =====
// Self-checking testbench for the ray/box occlusion core: table loads, queries, stalls.
`default_nettype none
module ray_box_occlusion_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbo_pkg::*;

    localparam int  LATENCY_TAIL = 600;
    localparam int  IDLE_LIMIT   = 60000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  Q1           = 16384;

    typedef struct packed {
        logic           sync;
        logic [1:0]     kind;
        logic [1:0]     row;
        q14_t [2:0]     a;
        q14_t [2:0]     b;
    } req_t;

    typedef struct packed {
        logic       visible;
        logic [1:0] status;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    ray_box_occlusion_test_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    // Mirror of the box table
    q14_t        ctr_mem  [3*MAX_BOXES];
    q14_t        size_mem [3*MAX_BOXES];
    q14_t        rot_mem  [9*MAX_BOXES];
    int unsigned n_boxes = 0;

    req_t    pending_reqs[$];
    answer_t answers_due[$];
    req_t    cur_req;
    int      n_fail = 0, n_results = 0, n_queries = 0, n_blocked = 0;

    // Append one word to the stimulus queue
    task automatic queue_req(req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic longint unsigned sum_sq(longint v0, longint v1, longint v2);
        longint unsigned s, a, t;
        longint v[3];
        v = '{v0, v1, v2};
        s = 0;
        for (int i = 0; i < 3; i++) begin
            a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            t = s + a * a;
            s = (t < s) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // Q14 quotient, truncated, clamped to +-2^40
    function automatic longint slab_div(longint num, longint den);
        longint q, r;
        q = num / den;
        r = num % den;
        if (q >= (64'sd1 <<< 26)) return 64'sd1 <<< 40;
        if (q <= -(64'sd1 <<< 26)) return -(64'sd1 <<< 40);
        return q * 16384 + (r * 16384) / den;
    endfunction

    function automatic logic ray_clear(q14_t [2:0] cam_w, q14_t [2:0] tgt_w);
        longint cam[3], d[3], u[3], p[3], e[3], f[3], sz[3];
        longint len, m, lim, tmin, tmax, e2, t1, t2, tt;
        longint unsigned lsq, dsq, a;
        logic hit;
        for (int i = 0; i < 3; i++) begin
            cam[i] = longint'(cam_w[i]);
            d[i] = longint'(tgt_w[i]) - cam[i];
        end
        lsq = sum_sq(d[0], d[1], d[2]);
        if (lsq == 0) return 1'b1;
        len = longint'(int_sqrt(lsq));
        for (int i = 0; i < 3; i++) u[i] = (d[i] * 16384) / len;
        for (int unsigned bx = 0; bx < n_boxes; bx++) begin
            hit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                p[i]  = longint'(ctr_mem[bx*3+i]) - cam[i];
                sz[i] = longint'(size_mem[bx*3+i]);
            end
            dsq = sum_sq(p[0], p[1], p[2]);
            m = sz[0];
            if (sz[1] > m) m = sz[1];
            if (sz[2] > m) m = sz[2];
            lim = len + m + m / 2;
            a = (lim < 0) ? longint'(-lim) : longint'(lim);
            // skip boxes out of reach or around the camera
            if (a < (64'd1 << 32) && dsq > a * a) continue;
            if (dsq < (64'd1 << 28)) continue;
            for (int i = 0; i < 3; i++) begin
                e[i] = 0;
                f[i] = 0;
                for (int j = 0; j < 3; j++) begin
                    e[i] += (p[j] * longint'(rot_mem[bx*9+i*3+j])) >>> 14;
                    f[i] += (u[j] * longint'(rot_mem[bx*9+i*3+j])) >>> 14;
                end
            end
            tmin = 0;
            tmax = len - 8192;
            for (int i = 0; i < 3; i++) begin
                e2 = 2 * e[i];
                if (f[i] != 0) begin
                    t1 = slab_div(e2 - sz[i], 2 * f[i]);
                    t2 = slab_div(e2 + sz[i], 2 * f[i]);
                    if (t1 > t2) begin
                        tt = t1; t1 = t2; t2 = tt;
                    end
                    if (t1 > tmin) tmin = t1;
                    if (t2 < tmax) tmax = t2;
                    if (tmin > tmax) begin
                        hit = 1'b0;
                        break;
                    end
                end else if (e2 < -sz[i] || e2 > sz[i]) begin
                    hit = 1'b0;
                    break;
                end
            end
            if (hit && tmax >= 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one accepted word to the table mirror and return its answer
    function automatic answer_t apply_req(req_t r);
        answer_t ans;
        ans = '{visible: 1'b0, status: ST_DONE};
        case (r.kind)
            REQ_CLEAR: n_boxes = 0;
            REQ_APPEND: begin
                if (n_boxes >= MAX_BOXES) begin
                    ans.status = ST_FULL;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        ctr_mem[n_boxes*3+i]  = r.a[i];
                        size_mem[n_boxes*3+i] = r.b[i];
                    end
                    n_boxes++;
                end
            end
            REQ_ROT: begin
                if (n_boxes == 0) ans.status = ST_NO_BOX;
                else if (r.row != ROW_NONE)
                    for (int i = 0; i < 3; i++) rot_mem[(n_boxes-1)*9 + r.row*3 + i] = r.a[i];
            end
            default: begin
                ans.visible = ray_clear(r.a, r.b);
                n_queries++;
                if (!ans.visible) n_blocked++;
            end
        endcase
        return ans;
    endfunction

    // Gap length: mostly none or short, sometimes long; bursts run with no gaps
    logic burst_mode = 1'b0;
    function automatic int pick_gap();
        int k;
        if (burst_mode) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: advance to the next word once the current one is taken
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                answers_due = {answers_due, apply_req(cur_req)};
            if ($urandom_range(0, 199) == 0) burst_mode = ~burst_mode;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].sync && answers_due.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {cur_req.b, cur_req.a};
                    s_axis_tuser  <= {cur_req.row, cur_req.kind};
                    s_axis_tvalid <= 1'b1;
                    drv_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest expectation
    int  hold_cnt = 0;
    logic hold_done = 1'b0;
    answer_t got, want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got = '{visible: m_axis_tdata[0], status: m_axis_tuser};
                if (answers_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR: result word with nothing expected: visible=%0d status=%0d",
                                 got.visible, got.status);
                end else begin
                    want = answers_due.pop_front();
                    if (got.visible !== want.visible || got.status !== want.status) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("ERROR: result %0d: expected visible=%0d status=%0d, got visible=%0d status=%0d",
                                     n_results, want.visible, want.status, got.visible, got.status);
                    end
                end
            end
            // one long hold-off partway through the random loads
            if (!hold_done && n_results == 40) begin
                hold_done = 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= burst_mode ? 1'b1 : ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Watchdog: stop when no word moves for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic q14_t near_val(int units);
        return q14_t'($signed($urandom_range(0, 2 * units * Q1)) - units * Q1);
    endfunction

    function automatic req_t mk(logic [1:0] kind, logic [1:0] row,
                                q14_t ax, q14_t ay, q14_t az, q14_t bx, q14_t by, q14_t bz);
        req_t r;
        r.sync = 1'b0;
        r.kind = kind;
        r.row  = row;
        r.a = {az, ay, ax};
        r.b = {bz, by, bx};
        return r;
    endfunction

    // Append one box and write its three rotation rows in random order
    int gen_boxes = 0;
    task automatic add_box(logic wild);
        int order[3];
        int k, t;
        q14_t rv[3];
        if (wild)
            queue_req(mk(REQ_APPEND, 2'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom));
        else
            queue_req(mk(REQ_APPEND, 2'($urandom), near_val(20), near_val(20),
                         near_val(20), q14_t'($urandom_range(Q1/2, 8*Q1)),
                         q14_t'($urandom_range(Q1/2, 8*Q1)),
                         q14_t'($urandom_range(Q1/2, 8*Q1))));
        gen_boxes++;
        order = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = order[i]; order[i] = order[k]; order[k] = t;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (wild) rv[j] = $urandom;
                else if ($urandom_range(0, 1)) rv[j] = near_val(1);
                else rv[j] = (j == order[i]) ? q14_t'(Q1) : q14_t'(0);
            end
            queue_req(mk(REQ_ROT, 2'(order[i]), rv[0], rv[1], rv[2], 0, 0, 0));
            if ($urandom_range(0, 7) == 0)
                queue_req(mk(REQ_ROT, ROW_NONE, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
        end
    endtask

    task automatic add_query(logic wild);
        if (wild)
            queue_req(mk(REQ_QUERY, 2'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom));
        else
            queue_req(mk(REQ_QUERY, 2'($urandom), near_val(25), near_val(25),
                         near_val(25), near_val(25), near_val(25), near_val(25)));
    endtask

    // Stimulus and end of run
    initial begin
        req_t r;
        int k;
        // directed: empty table, missing box, one axis-aligned box
        add_query(1'b0);
        queue_req(mk(REQ_ROT, 2'd1, Q1, 0, 0, 0, 0, 0));
        queue_req(mk(REQ_APPEND, 2'd0, 5*Q1, 0, 0, 2*Q1, 2*Q1, 2*Q1));
        queue_req(mk(REQ_ROT, 2'd0, Q1, 0, 0, 0, 0, 0));
        queue_req(mk(REQ_ROT, 2'd1, 0, Q1, 0, 0, 0, 0));
        queue_req(mk(REQ_ROT, 2'd2, 0, 0, Q1, 0, 0, 0));
        queue_req(mk(REQ_ROT, ROW_NONE, -1, -1, -1, -1, -1, -1));
        queue_req(mk(REQ_QUERY, 2'd0, 0, 0, 0, 10*Q1, 0, 0));
        queue_req(mk(REQ_QUERY, 2'd0, 0, 0, 0, 0, 0, 0));
        queue_req(mk(REQ_QUERY, 2'd0, 0, 0, 0, -10*Q1, 0, 0));
        queue_req(mk(REQ_QUERY, 2'd0, 0, 0, 0, 0, 10*Q1, 0));
        queue_req(mk(REQ_QUERY, 2'd0, 0, 0, 0, 5*Q1, 0, 0));
        queue_req(mk(REQ_QUERY, 2'd3, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // extreme box
        queue_req(mk(REQ_APPEND, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        queue_req(mk(REQ_ROT, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
        queue_req(mk(REQ_ROT, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
        queue_req(mk(REQ_ROT, 2'd2, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
        queue_req(mk(REQ_QUERY, 2'd0, 32'h8000_0000, 0, 32'h8000_0000,
                     32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
        add_query(1'b1);
        queue_req(mk(REQ_CLEAR, 2'd0, 0, 0, 0, 0, 0, 0));
        add_query(1'b0);
        gen_boxes = 0;
        // random scenes: mostly well-formed boxes and queries, some wild values
        for (int n = 0; n < 50; n++) begin
            k = $urandom_range(0, 99);
            if (k < 5) begin
                queue_req(mk(REQ_CLEAR, 2'($urandom), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
                gen_boxes = 0;
            end else if (k < 35 && gen_boxes < 8) begin
                add_box($urandom_range(0, 9) == 0);
            end else if (k < 42) begin
                queue_req(mk(REQ_ROT, 2'($urandom), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
            end else begin
                add_query($urandom_range(0, 9) < 2);
            end
            // sender waits once for everything to drain
            if (n == 30) begin
                r = mk(REQ_QUERY, 2'd0, 0, 0, 0, 3*Q1, Q1, 0);
                r.sync = 1'b1;
                queue_req(r);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY_TAIL) @(posedge aclk);
        if (answers_due.size() != 0) n_fail++;
        $display("Covered %0d result words: %0d queries (%0d blocked), box appends,",
                 n_results, n_queries, n_blocked);
        $display("missing-box and ignored row writes, clears, long output hold and a drain pause.");
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/rbo_pkg.sv
design/ray_box_occlusion_test_core.sv
verif/ray_box_occlusion_test_core_tb.sv
